// ----- design/quadratic_root_solver_core_assert.svh -----
// ----------------------------------------------------------------------------
// quadratic_root_solver_core_assert.svh
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_CORE_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_ASSERT_SVH

// same-cycle implication
`define QRS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// widths, kind codes, pipeline types and the 32-bit clamp
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int COEF_W     = 16;
   localparam int NB_W       = 25;
   localparam int RAD_W      = 50;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int SQRT_STEPS = RAD_W / 2;
   localparam int SQRT_REM_W = ROOT_W + 2;
   localparam int QUO_W      = 33;
   localparam int DIV_STEPS  = QUO_W;
   localparam int VAL_W      = 32;
   localparam int WIDE_W     = 48;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_DOUBLE  = 2'd1;
   localparam logic [1:0] KIND_TWO     = 2'd2;
   localparam logic [1:0] KIND_INVALID = 2'd3;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [COEF_W-1:0] coef_c;
   } coef_type;

   typedef struct packed {
      logic [1:0]              root_kind;
      logic signed [VAL_W-1:0] root_minus;
      logic signed [VAL_W-1:0] root_plus;
      logic signed [VAL_W-1:0] root_product;
      logic signed [VAL_W-1:0] root_sum;
      logic                    saturated;
   } result_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic signed [NB_W-1:0]   neg_b;
      logic signed [COEF_W-1:0] coef_a;
      logic [RAD_W-1:0]         rad;
      logic [SQRT_REM_W-1:0]    rem;
      logic [ROOT_W-1:0]        root;
   } sqrt_work_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic              sign_m;
      logic              sign_p;
      logic [COEF_W-1:0] den;
      logic [QUO_W-1:0]  num_m;
      logic [QUO_W-1:0]  num_p;
      logic [COEF_W-1:0] rem_m;
      logic [COEF_W-1:0] rem_p;
   } div_work_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] val;
      logic                    sat;
   } clamp_type;

   function automatic clamp_type clamp_val(input logic signed [WIDE_W-1:0] v);
      clamp_type r;
      if ((&v[WIDE_W-1:VAL_W-1]) || !(|v[WIDE_W-1:VAL_W-1])) begin
         r.val = v[VAL_W-1:0];
         r.sat = 1'b0;
      end else begin
         r.val = {v[WIDE_W-1], {(VAL_W-1){~v[WIDE_W-1]}}};
         r.sat = 1'b1;
      end
      return r;
   endfunction

endpackage

// ----- design/qrs_if.sv -----
// ----------------------------------------------------------------------------
// qrs_if
// valid/ready channels for coefficient items and result items
// ----------------------------------------------------------------------------
interface qrs_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [qrs_pkg::COEF_W-1:0] coef_a;
   logic signed [qrs_pkg::COEF_W-1:0] coef_b;
   logic signed [qrs_pkg::COEF_W-1:0] coef_c;

   modport source (output valid, coef_a, coef_b, coef_c, input ready);
   modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       root_kind;
   logic signed [qrs_pkg::VAL_W-1:0] root_minus;
   logic signed [qrs_pkg::VAL_W-1:0] root_plus;
   logic signed [qrs_pkg::VAL_W-1:0] root_product;
   logic signed [qrs_pkg::VAL_W-1:0] root_sum;
   logic                             saturated;

   modport source (output valid, root_kind, root_minus, root_plus, root_product,
                   root_sum, saturated, input ready);
   modport sink   (input valid, root_kind, root_minus, root_plus, root_product,
                   root_sum, saturated, output ready);
endinterface

// ----- design/quadratic_root_solver_core.sv -----
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// real roots of a*x^2 + b*x + c from Q8.8 coefficients, results in Q16.16
//
//   channel   direction  payload
//   req_chan  in         coef_a, coef_b, coef_c
//   rsp_chan  out        root_kind, root_minus, root_plus, root_product,
//                        root_sum, saturated
//
// one item per cycle while the result channel is not stalled; sections in order: discriminant,
// square root, divider (setup plus one quotient bit a stage), then clamp, product and output
// reset clears every stage valid bit; no state survives an item
// each stage holds while the stage after it is full and stalled, so a
// stalled result register still lets items fill the empty stages behind it
// ----------------------------------------------------------------------------
module quadratic_root_solver_core (
   input logic      clock,
   input logic      reset,
   qrs_req_if.sink  req_chan,
   qrs_rsp_if.source rsp_chan
);
   import qrs_pkg::*;

   coef_type      coef;
   sqrt_work_type disc_data, sqrt_data;
   div_work_type  div_data;
   result_type    res;
   logic          disc_valid, disc_ready;
   logic          sqrt_valid, sqrt_ready;
   logic          div_valid, div_ready;

   assign coef.coef_a = req_chan.coef_a;
   assign coef.coef_b = req_chan.coef_b;
   assign coef.coef_c = req_chan.coef_c;

   qrs_disc u_disc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (coef),
      .out_valid (disc_valid),
      .out_ready (disc_ready),
      .out_data  (disc_data)
   );

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (disc_valid),
      .in_ready  (disc_ready),
      .in_data   (disc_data),
      .out_valid (sqrt_valid),
      .out_ready (sqrt_ready),
      .out_data  (sqrt_data)
   );

   qrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sqrt_valid),
      .in_ready  (sqrt_ready),
      .in_data   (sqrt_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   qrs_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (res)
   );

   assign rsp_chan.root_kind    = res.root_kind;
   assign rsp_chan.root_minus   = res.root_minus;
   assign rsp_chan.root_plus    = res.root_plus;
   assign rsp_chan.root_product = res.root_product;
   assign rsp_chan.root_sum     = res.root_sum;
   assign rsp_chan.saturated    = res.saturated;
endmodule

// ----- design/qrs_disc.sv -----
// ----------------------------------------------------------------------------
// qrs_disc
// two stages: coefficient products, then discriminant and classification
// ----------------------------------------------------------------------------
module qrs_disc (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  qrs_pkg::coef_type      in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output qrs_pkg::sqrt_work_type out_data
);
   import qrs_pkg::*;

   typedef struct packed {
      logic signed [COEF_W-1:0]   coef_a;
      logic signed [COEF_W-1:0]   coef_b;
      logic signed [2*COEF_W-1:0] bb;
      logic signed [2*COEF_W-1:0] ac;
   } prod_type;

   prod_type      p_ff, p_in;
   logic          p_vld_ff;
   sqrt_work_type d_ff, d_in;
   logic          d_vld_ff;
   logic          p_rdy, d_rdy;
   logic signed [2*COEF_W+2:0] delta;

   assign d_rdy    = !d_vld_ff || out_ready;
   assign p_rdy    = !p_vld_ff || d_rdy;
   assign in_ready = p_rdy;

   always_comb begin
      p_in.coef_a = in_data.coef_a;
      p_in.coef_b = in_data.coef_b;
      p_in.bb     = $signed(in_data.coef_b) * $signed(in_data.coef_b);
      p_in.ac     = $signed(in_data.coef_a) * $signed(in_data.coef_c);
   end

   always_comb begin
      delta = $signed({{3{p_ff.bb[2*COEF_W-1]}}, p_ff.bb})
            - $signed({p_ff.ac[2*COEF_W-1], p_ff.ac, 2'b00});
      d_in.coef_a = p_ff.coef_a;
      d_in.neg_b  = -$signed({p_ff.coef_b[COEF_W-1], p_ff.coef_b, 8'b0});
      d_in.rem    = '0;
      d_in.root   = '0;
      d_in.rad    = '0;
      if (p_ff.coef_a == '0) begin
         d_in.kind = KIND_INVALID;
      end else if (delta[2*COEF_W+2]) begin
         d_in.kind = KIND_NONE;
      end else if (delta == '0) begin
         d_in.kind = KIND_DOUBLE;
      end else begin
         d_in.kind = KIND_TWO;
         d_in.rad  = {delta[RAD_W-17:0], 16'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         if (p_rdy) p_vld_ff <= in_valid;
         if (d_rdy) d_vld_ff <= p_vld_ff;
      end
      if (p_rdy) p_ff <= p_in;
      if (d_rdy) d_ff <= d_in;
   end

   assign out_valid = d_vld_ff;
   assign out_data  = d_ff;
endmodule

// ----- design/qrs_sqrt.sv -----
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined floor square root, one root bit per stage
// ----------------------------------------------------------------------------
module qrs_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  qrs_pkg::sqrt_work_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output qrs_pkg::sqrt_work_type out_data
);
   import qrs_pkg::*;

   sqrt_work_type stage_ff [SQRT_STEPS];
   logic          vld_ff   [SQRT_STEPS];
   logic          rdy      [SQRT_STEPS+1];

   assign rdy[SQRT_STEPS] = out_ready;
   assign in_ready        = rdy[0];

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
      sqrt_work_type         prev;
      sqrt_work_type         step_in;
      logic                  prev_vld;
      logic [SQRT_REM_W-1:0] cur;
      logic [SQRT_REM_W-1:0] trial;

      if (i == 0) begin : g_head
         assign prev     = in_data;
         assign prev_vld = in_valid;
      end else begin : g_body
         assign prev     = stage_ff[i-1];
         assign prev_vld = vld_ff[i-1];
      end

      assign rdy[i] = !vld_ff[i] || rdy[i+1];

      always_comb begin
         step_in     = prev;
         cur         = {prev.rem[SQRT_REM_W-3:0], prev.rad[RAD_W-1:RAD_W-2]};
         trial       = {prev.root, 2'b01};
         step_in.rad = {prev.rad[RAD_W-3:0], 2'b00};
         if (cur >= trial) begin
            step_in.rem  = cur - trial;
            step_in.root = {prev.root[ROOT_W-2:0], 1'b1};
         end else begin
            step_in.rem  = cur;
            step_in.root = {prev.root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            vld_ff[i] <= prev_vld;
         end
         if (rdy[i]) stage_ff[i] <= step_in;
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS-1];
   assign out_data  = stage_ff[SQRT_STEPS-1];
endmodule

// ----- design/qrs_div.sv -----
// ----------------------------------------------------------------------------
// qrs_div
// numerator setup, then two restoring dividers side by side, one bit a stage
// ----------------------------------------------------------------------------
module qrs_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  qrs_pkg::sqrt_work_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output qrs_pkg::div_work_type  out_data
);
   import qrs_pkg::*;

   localparam int NumStages = DIV_STEPS + 1;
   localparam int N_W       = NB_W + 2;

   div_work_type stage_ff [NumStages];
   logic         vld_ff   [NumStages];
   logic         rdy      [NumStages+1];

   assign rdy[NumStages] = out_ready;
   assign in_ready       = rdy[0];

   for (genvar i = 0; i < NumStages; i++) begin : g_step
      div_work_type step_in;
      logic         prev_vld;

      assign rdy[i] = !vld_ff[i] || rdy[i+1];

      if (i == 0) begin : g_head
         logic signed [N_W-1:0]   nm;
         logic signed [N_W-1:0]   np;
         logic signed [N_W+6:0]   sm;
         logic signed [N_W+6:0]   sp;

         assign prev_vld = in_valid;

         always_comb begin
            nm = $signed({{2{in_data.neg_b[NB_W-1]}}, in_data.neg_b})
               - $signed({2'b00, in_data.root});
            np = $signed({{2{in_data.neg_b[NB_W-1]}}, in_data.neg_b})
               + $signed({2'b00, in_data.root});
            sm = nm[N_W-1] ? -$signed({nm, 7'b0}) : $signed({nm, 7'b0});
            sp = np[N_W-1] ? -$signed({np, 7'b0}) : $signed({np, 7'b0});
            step_in.kind   = in_data.kind;
            step_in.sign_m = nm[N_W-1] ^ in_data.coef_a[COEF_W-1];
            step_in.sign_p = np[N_W-1] ^ in_data.coef_a[COEF_W-1];
            step_in.den    = in_data.coef_a[COEF_W-1] ? COEF_W'(-in_data.coef_a)
                                                      : in_data.coef_a;
            step_in.num_m  = sm[QUO_W-1:0];
            step_in.num_p  = sp[QUO_W-1:0];
            step_in.rem_m  = '0;
            step_in.rem_p  = '0;
         end
      end else begin : g_body
         div_work_type      prev;
         logic [COEF_W:0]   cur_m;
         logic [COEF_W:0]   cur_p;
         logic [COEF_W:0]   diff_m;
         logic [COEF_W:0]   diff_p;

         assign prev     = stage_ff[i-1];
         assign prev_vld = vld_ff[i-1];

         always_comb begin
            step_in = prev;
            cur_m   = {prev.rem_m, prev.num_m[QUO_W-1]};
            cur_p   = {prev.rem_p, prev.num_p[QUO_W-1]};
            diff_m  = cur_m - {1'b0, prev.den};
            diff_p  = cur_p - {1'b0, prev.den};
            if (cur_m >= {1'b0, prev.den}) begin
               step_in.rem_m = diff_m[COEF_W-1:0];
               step_in.num_m = {prev.num_m[QUO_W-2:0], 1'b1};
            end else begin
               step_in.rem_m = cur_m[COEF_W-1:0];
               step_in.num_m = {prev.num_m[QUO_W-2:0], 1'b0};
            end
            if (cur_p >= {1'b0, prev.den}) begin
               step_in.rem_p = diff_p[COEF_W-1:0];
               step_in.num_p = {prev.num_p[QUO_W-2:0], 1'b1};
            end else begin
               step_in.rem_p = cur_p[COEF_W-1:0];
               step_in.num_p = {prev.num_p[QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            vld_ff[i] <= prev_vld;
         end
         if (rdy[i]) stage_ff[i] <= step_in;
      end
   end

   assign out_valid = vld_ff[NumStages-1];
   assign out_data  = stage_ff[NumStages-1];
endmodule

// ----- design/qrs_post.sv -----
// ----------------------------------------------------------------------------
// qrs_post
// signed roots with clamp, product and sum, final scaling and output register
// ----------------------------------------------------------------------------
module qrs_post (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  qrs_pkg::div_work_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output qrs_pkg::result_type   out_data
);
   import qrs_pkg::*;

   typedef struct packed {
      logic [1:0]              kind;
      logic signed [VAL_W-1:0] rm;
      logic signed [VAL_W-1:0] rp;
      logic                    sat;
   } root_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [VAL_W-1:0]   rm;
      logic signed [VAL_W-1:0]   rp;
      logic signed [2*VAL_W-1:0] prod;
      logic signed [VAL_W:0]     sum;
      logic                      sat;
   } mul_type;

   root_type   r_ff, r_in;
   mul_type    m_ff, m_in;
   result_type o_ff, o_in;
   logic       r_vld_ff, m_vld_ff, o_vld_ff;
   logic       r_rdy, m_rdy, o_rdy;

   logic signed [QUO_W:0]     qm, qp;
   clamp_type                 cm, cp, cprod, csum;
   logic signed [2*VAL_W-1:0] prod_adj;

   assign o_rdy    = !o_vld_ff || out_ready;
   assign m_rdy    = !m_vld_ff || o_rdy;
   assign r_rdy    = !r_vld_ff || m_rdy;
   assign in_ready = r_rdy;

   always_comb begin
      qm        = in_data.sign_m ? -$signed({1'b0, in_data.num_m})
                                 : $signed({1'b0, in_data.num_m});
      qp        = in_data.sign_p ? -$signed({1'b0, in_data.num_p})
                                 : $signed({1'b0, in_data.num_p});
      cm        = clamp_val(WIDE_W'(qm));
      cp        = clamp_val(WIDE_W'(qp));
      r_in.kind = in_data.kind;
      r_in.rm   = cm.val;
      r_in.rp   = cp.val;
      r_in.sat  = cm.sat | cp.sat;
   end

   always_comb begin
      m_in.kind = r_ff.kind;
      m_in.rm   = r_ff.rm;
      m_in.rp   = r_ff.rp;
      m_in.prod = r_ff.rm * r_ff.rp;
      m_in.sum  = $signed({r_ff.rm[VAL_W-1], r_ff.rm}) + $signed({r_ff.rp[VAL_W-1], r_ff.rp});
      m_in.sat  = r_ff.sat;
   end

   always_comb begin
      prod_adj = m_ff.prod + (m_ff.prod[2*VAL_W-1] ? (2*VAL_W)'(16'hFFFF) : '0);
      cprod    = clamp_val(WIDE_W'(prod_adj >>> 16));
      csum     = clamp_val(WIDE_W'(m_ff.sum));
      o_in.root_kind = m_ff.kind;
      case (m_ff.kind) inside
         KIND_NONE, KIND_INVALID: begin
            o_in.root_minus   = '0;
            o_in.root_plus    = '0;
            o_in.root_product = '0;
            o_in.root_sum     = '0;
            o_in.saturated    = 1'b0;
         end
         default: begin
            o_in.root_minus   = m_ff.rm;
            o_in.root_plus    = m_ff.rp;
            o_in.root_product = cprod.val;
            o_in.root_sum     = csum.val;
            o_in.saturated    = m_ff.sat | cprod.sat | csum.sat;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
         m_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         if (r_rdy) r_vld_ff <= in_valid;
         if (m_rdy) m_vld_ff <= r_vld_ff;
         if (o_rdy) o_vld_ff <= m_vld_ff;
      end
      if (r_rdy) r_ff <= r_in;
      if (m_rdy) m_ff <= m_in;
      if (o_rdy) o_ff <= o_in;
   end

   assign out_valid = o_vld_ff;
   assign out_data  = o_ff;
endmodule

// ----- design/qrs_checker.sv -----
// ----------------------------------------------------------------------------
// qrs_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_core_assert.svh"

module qrs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [1:0]                       root_kind,
   input logic signed [qrs_pkg::VAL_W-1:0] root_minus,
   input logic signed [qrs_pkg::VAL_W-1:0] root_plus,
   input logic signed [qrs_pkg::VAL_W-1:0] root_product,
   input logic signed [qrs_pkg::VAL_W-1:0] root_sum,
   input logic                             saturated
);
   import qrs_pkg::*;

   `QRS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "item out of reset")

   `QRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(root_kind) && $stable(root_minus) && $stable(root_product),
      "stalled item changed")

   `QRS_ASSERT_IMPL(a_no_root_zero, clock, reset,
      rsp_valid && (root_kind == KIND_NONE || root_kind == KIND_INVALID),
      root_minus == '0 && root_plus == '0 && root_product == '0 && root_sum == '0
      && !saturated, "nonzero fields without roots")

   `QRS_ASSERT_IMPL(a_double_equal, clock, reset,
      rsp_valid && root_kind == KIND_DOUBLE, root_minus == root_plus,
      "double root halves differ")
endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .root_kind    (rsp_chan.root_kind),
   .root_minus   (rsp_chan.root_minus),
   .root_plus    (rsp_chan.root_plus),
   .root_product (rsp_chan.root_product),
   .root_sum     (rsp_chan.root_sum),
   .saturated    (rsp_chan.saturated)
);
